// ===== rtl/core/fsl_pkg.sv =====
// shared types, constants and result builders for the fix session layer
`timescale 1ns / 1ps
package fsl_pkg;

    localparam int SEQ_WIDTH_DEF   = 32;
    localparam int TIMER_WIDTH_DEF = 16;

    localparam logic        RST_IS_SERVER = 1'b0;
    localparam logic [15:0] RST_INIT_HB   = 16'd30;
    localparam logic [15:0] RST_MIN_HB    = 16'd5;
    localparam logic [15:0] RST_MAX_HB    = 16'd120;
    localparam logic [7:0]  RST_LOGOUT_TO = 8'd10;

    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_IS_SERVER = 3'd0,
        REG_INIT_HB   = 3'd1,
        REG_MIN_HB    = 3'd2,
        REG_MAX_HB    = 3'd3,
        REG_LOGOUT_TO = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_MSG    = 2'd0,
        EV_TICK   = 2'd1,
        EV_START  = 2'd2,
        EV_LOGOUT = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        K_HB     = 3'd0,
        K_TR     = 3'd1,
        K_LOGOUT = 3'd2,
        K_LOGON  = 3'd3,
        K_OTHER  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        SEND_HB     = 2'd0,
        SEND_TR     = 2'd1,
        SEND_LOGOFF = 2'd2,
        SEND_LOGON  = 2'd3
    } t_send;

    typedef enum logic [3:0] {
        R_NONE            = 4'd0,
        R_SEQ             = 4'd1,
        R_HB_RANGE        = 4'd2,
        R_DISC            = 4'd3,
        R_LOGON_WAIT      = 4'd4,
        R_LOGOUT_IN_LOGON = 4'd5,
        R_LOGON_EST       = 4'd6,
        R_LOGOUT_CONF     = 4'd7,
        R_TR_TIMEOUT      = 4'd8,
        R_LOGOUT_TIMEOUT  = 4'd9,
        R_PEER_LOGOUT     = 4'd10
    } t_reason;

    localparam logic KIND_MSG  = 1'b0;
    localparam logic KIND_NOTE = 1'b1;

    typedef struct packed {
        logic        is_server;
        logic [15:0] init_hb;
        logic [15:0] min_hb;
        logic [15:0] max_hb;
        logic [7:0]  logout_to;
    } t_cfg;

    // classified event as it sits in the queue
    typedef struct packed {
        t_func       func;
        t_kind       kind;
        logic [31:0] seq;
        logic [15:0] hb;
        logic        hb_ok;
        logic        has_id;
        logic [31:0] id;
    } t_evt;

    typedef struct packed {
        logic        kind;
        t_send       typ;
        logic [31:0] seq;
        logic [15:0] hb;
        logic        has_id;
        logic [31:0] id;
        t_reason     reason;
        logic        last;
    } t_res;

    function automatic t_res mk_msg(t_send typ, logic [31:0] seq, logic [15:0] hb,
                                    logic has_id, logic [31:0] id, t_reason rsn);
        t_res r;
        r        = '0;
        r.kind   = KIND_MSG;
        r.typ    = typ;
        r.seq    = seq;
        r.hb     = hb;
        r.has_id = has_id;
        r.id     = has_id ? id : 32'd0;
        r.reason = rsn;
        return r;
    endfunction

    function automatic t_res mk_note(t_reason rsn);
        t_res r;
        r        = '0;
        r.kind   = KIND_NOTE;
        r.typ    = SEND_HB;
        r.reason = rsn;
        return r;
    endfunction

endpackage

// ===== rtl/core/fsl_if.sv =====
// valid/ready channel interfaces for session events and session results
`timescale 1ns / 1ps
interface fsl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  msg_kind;
    logic [31:0] msg_seq;
    logic [15:0] msg_heartbeat;
    logic        msg_has_id;
    logic [31:0] msg_id;

    modport source (output valid, func, msg_kind, msg_seq, msg_heartbeat, msg_has_id,
                    msg_id, input ready);
    modport sink   (input valid, func, msg_kind, msg_seq, msg_heartbeat, msg_has_id,
                    msg_id, output ready);
endinterface

interface fsl_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [1:0]  out_type;
    logic [31:0] out_seq;
    logic [15:0] out_heartbeat;
    logic        out_has_id;
    logic [31:0] out_id;
    logic [3:0]  out_reason;
    logic        out_last;

    modport source (output valid, out_kind, out_type, out_seq, out_heartbeat, out_has_id,
                    out_id, out_reason, out_last, input ready);
    modport sink   (input valid, out_kind, out_type, out_seq, out_heartbeat, out_has_id,
                    out_id, out_reason, out_last, output ready);
endinterface

// ===== rtl/core/fsl_front.sv =====
// front end: accepts session events and classifies them for the queue
`timescale 1ns / 1ps
module fsl_front (
    fsl_in_if.sink        i_in,
    input  fsl_pkg::t_cfg i_cfg,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output fsl_pkg::t_evt o_push_data
);
    import fsl_pkg::*;

    t_kind w_kind;

    always_comb begin
        case (i_in.msg_kind)
            K_HB:     w_kind = K_HB;
            K_TR:     w_kind = K_TR;
            K_LOGOUT: w_kind = K_LOGOUT;
            K_LOGON:  w_kind = K_LOGON;
            default:  w_kind = K_OTHER;
        endcase
    end

    assign o_push_valid       = i_in.valid;
    assign i_in.ready         = i_push_ready;
    assign o_push_data.func   = t_func'(i_in.func);
    assign o_push_data.kind   = w_kind;
    assign o_push_data.seq    = i_in.msg_seq;
    assign o_push_data.hb     = i_in.msg_heartbeat;
    // server hb range; user must keep config stable while events in flight
    assign o_push_data.hb_ok  = (i_in.msg_heartbeat >= i_cfg.min_hb) &&
                                (i_in.msg_heartbeat <= i_cfg.max_hb);
    assign o_push_data.has_id = i_in.msg_has_id;
    assign o_push_data.id     = i_in.msg_id;

endmodule

// ===== rtl/core/fsl_queue.sv =====
// two-entry event queue between front and back
`timescale 1ns / 1ps
module fsl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  fsl_pkg::t_evt i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output fsl_pkg::t_evt o_pop_data
);
    import fsl_pkg::*;

    t_evt       r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_slot[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wptr] <= i_push_data;
    end

endmodule

// ===== rtl/core/fsl_back.sv =====
// back end: session state machine, timers and result buffer
`timescale 1ns / 1ps
module fsl_back #(
    parameter int SEQ_WIDTH   = fsl_pkg::SEQ_WIDTH_DEF,
    parameter int TIMER_WIDTH = fsl_pkg::TIMER_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fsl_pkg::t_cfg i_cfg,
    input  logic          i_evt_valid,
    output logic          o_evt_ready,
    input  fsl_pkg::t_evt i_evt,
    fsl_out_if.source     o_out
);
    import fsl_pkg::*;

    localparam int CW   = (SEQ_WIDTH > 32) ? SEQ_WIDTH : 32;
    localparam int CMPW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 3;

    typedef enum logic [3:0] {
        MODE_DISC   = 4'b0001,
        MODE_LOGON  = 4'b0010,
        MODE_EST    = 4'b0100,
        MODE_LOGOUT = 4'b1000
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic                   r_run, n_run;
    logic                   r_shut, n_shut;
    logic [SEQ_WIDTH-1:0]   r_recv_seq, n_recv_seq;
    logic [SEQ_WIDTH-1:0]   r_send_seq, n_send_seq;
    logic [15:0]            r_hb, n_hb;
    logic [TIMER_WIDTH-1:0] r_idle_recv, n_idle_recv;
    logic [TIMER_WIDTH-1:0] r_idle_send, n_idle_send;
    logic                   r_await, n_await;
    logic [31:0]            r_pend_id, n_pend_id;
    logic [7:0]             r_logout_s, n_logout_s;

    t_res                   r_res0, r_res1, w_res0, w_res1;
    logic [1:0]             r_cnt, w_nres;

    logic                   w_take, w_pop, w_seq_ok;
    logic [SEQ_WIDTH-1:0]   w_send_p1, w_send_p2, w_recv_p1;
    logic [TIMER_WIDTH-1:0] w_recv_inc, w_send_inc;
    logic [7:0]             w_logout_inc;
    logic [CMPW-1:0]        w_ir, w_is, w_hbx;
    logic                   w_tr_timeout, w_tr_trig, w_hb_due, w_tr_due;

    assign w_take      = o_out.valid && o_out.ready;
    // load a new event only when the result buffer is empty or drains this cycle
    assign w_pop       = i_evt_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_take));
    assign o_evt_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_take);

    assign w_seq_ok  = (CW'(i_evt.seq) == CW'(r_recv_seq));
    assign w_send_p1 = r_send_seq + SEQ_WIDTH'(1);
    assign w_send_p2 = r_send_seq + SEQ_WIDTH'(2);
    assign w_recv_p1 = r_recv_seq + SEQ_WIDTH'(1);

    assign w_recv_inc   = (&r_idle_recv) ? r_idle_recv : r_idle_recv + 1'b1;
    assign w_send_inc   = (&r_idle_send) ? r_idle_send : r_idle_send + 1'b1;
    assign w_logout_inc = (&r_logout_s) ? r_logout_s : r_logout_s + 1'b1;

    // floor compares rewritten without division:
    // i >= floor(3h/2) <=> 2i+2 > 3h, i >= floor(6h/5) <=> 5i+5 > 6h
    assign w_ir  = CMPW'(w_recv_inc);
    assign w_is  = CMPW'(w_send_inc);
    assign w_hbx = CMPW'(r_hb);
    assign w_tr_timeout = ((w_ir << 1) + CMPW'(2)) > ((w_hbx << 1) + w_hbx);
    assign w_tr_trig    = ((w_ir << 2) + w_ir + CMPW'(5)) > ((w_hbx << 2) + (w_hbx << 1));
    assign w_hb_due     = w_is >= w_hbx;
    assign w_tr_due     = !r_await && w_tr_trig;

    always_comb begin
        n_mode      = r_mode;
        n_run       = r_run;
        n_shut      = r_shut;
        n_recv_seq  = r_recv_seq;
        n_send_seq  = r_send_seq;
        n_hb        = r_hb;
        n_idle_recv = r_idle_recv;
        n_idle_send = r_idle_send;
        n_await     = r_await;
        n_pend_id   = r_pend_id;
        n_logout_s  = r_logout_s;
        w_res0      = '0;
        w_res1      = '0;
        w_nres      = 2'd0;
        if (w_pop) begin
            case (i_evt.func)
                EV_START: begin
                    if (!r_shut) begin
                        n_run       = 1'b1;
                        n_idle_recv = '0;
                        n_idle_send = '0;
                        if (r_mode == MODE_DISC) begin
                            n_hb = i_cfg.init_hb;
                            if (!i_cfg.is_server) begin
                                n_mode     = MODE_LOGON;
                                w_res0     = mk_msg(SEND_LOGON, 32'(r_send_seq),
                                                    i_cfg.init_hb, 1'b0, 32'd0, R_NONE);
                                w_nres     = 2'd1;
                                n_send_seq = w_send_p1;
                            end
                        end
                    end
                end
                EV_MSG: begin
                    if (r_run) begin
                        n_idle_recv = '0;
                        if (!w_seq_ok) begin
                            w_res0 = mk_note(R_SEQ);
                            w_nres = 2'd1;
                            n_run  = 1'b0;
                            n_shut = 1'b1;
                            n_mode = MODE_DISC;
                        end else begin
                            case (r_mode)
                                MODE_DISC: begin
                                    if (i_evt.kind != K_LOGON) begin
                                        w_res0 = mk_note(R_DISC);
                                        w_nres = 2'd1;
                                        n_run  = 1'b0;
                                        n_shut = 1'b1;
                                    end else begin
                                        n_recv_seq = w_recv_p1;
                                        if (i_cfg.is_server) begin
                                            n_idle_send = '0;
                                            n_send_seq  = w_send_p1;
                                            if (i_evt.hb_ok) begin
                                                n_hb    = i_evt.hb;
                                                w_res0  = mk_msg(SEND_LOGON, 32'(r_send_seq),
                                                                 i_evt.hb, 1'b0, 32'd0, R_NONE);
                                                w_nres  = 2'd1;
                                                n_mode  = MODE_EST;
                                                n_await = 1'b0;
                                            end else begin
                                                w_res0 = mk_msg(SEND_LOGOFF, 32'(r_send_seq),
                                                                16'd0, 1'b0, 32'd0, R_HB_RANGE);
                                                w_res1 = mk_note(R_HB_RANGE);
                                                w_nres = 2'd2;
                                                n_run  = 1'b0;
                                                n_shut = 1'b1;
                                            end
                                        end
                                    end
                                end
                                MODE_LOGON: begin
                                    if (i_evt.kind != K_LOGON) begin
                                        w_res0 = mk_note(R_LOGON_WAIT);
                                        w_nres = 2'd1;
                                        n_run  = 1'b0;
                                        n_shut = 1'b1;
                                        n_mode = MODE_DISC;
                                    end else begin
                                        n_recv_seq = w_recv_p1;
                                        n_mode     = MODE_EST;
                                        n_await    = 1'b0;
                                    end
                                end
                                MODE_LOGOUT: begin
                                    n_recv_seq = w_recv_p1;
                                    if (i_evt.kind == K_LOGOUT) begin
                                        w_res0 = mk_note(R_LOGOUT_CONF);
                                        w_nres = 2'd1;
                                        n_run  = 1'b0;
                                        n_shut = 1'b1;
                                        n_mode = MODE_DISC;
                                    end
                                end
                                MODE_EST: begin
                                    n_recv_seq = w_recv_p1;
                                    case (i_evt.kind)
                                        K_HB: begin
                                            if (i_evt.has_id && r_await &&
                                                (i_evt.id == r_pend_id)) n_await = 1'b0;
                                        end
                                        K_TR: begin
                                            w_res0      = mk_msg(SEND_HB, 32'(r_send_seq), 16'd0,
                                                                 i_evt.has_id, i_evt.id, R_NONE);
                                            w_nres      = 2'd1;
                                            n_send_seq  = w_send_p1;
                                            n_idle_send = '0;
                                        end
                                        K_LOGOUT: begin
                                            w_res0      = mk_msg(SEND_LOGOFF, 32'(r_send_seq),
                                                                 16'd0, 1'b0, 32'd0, R_PEER_LOGOUT);
                                            w_nres      = 2'd1;
                                            n_send_seq  = w_send_p1;
                                            n_idle_send = '0;
                                            n_mode      = MODE_LOGOUT;
                                            n_logout_s  = 8'd0;
                                        end
                                        K_LOGON: begin
                                            w_res0 = mk_note(R_LOGON_EST);
                                            w_nres = 2'd1;
                                            n_run  = 1'b0;
                                            n_shut = 1'b1;
                                            n_mode = MODE_DISC;
                                        end
                                        default: ;
                                    endcase
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                EV_TICK: begin
                    if (r_run) begin
                        n_idle_recv = w_recv_inc;
                        n_idle_send = w_send_inc;
                        if (r_mode == MODE_LOGOUT) begin
                            n_logout_s = w_logout_inc;
                            if (w_logout_inc >= i_cfg.logout_to) begin
                                w_res0 = mk_note(R_LOGOUT_TIMEOUT);
                                w_nres = 2'd1;
                                n_run  = 1'b0;
                                n_shut = 1'b1;
                                n_mode = MODE_DISC;
                            end
                        end else if (r_mode == MODE_EST) begin
                            if (r_await && w_tr_timeout) begin
                                w_res0 = mk_note(R_TR_TIMEOUT);
                                w_nres = 2'd1;
                                n_run  = 1'b0;
                                n_shut = 1'b1;
                                n_mode = MODE_DISC;
                            end else begin
                                if (w_tr_due) begin
                                    n_pend_id = r_pend_id + 32'd1;
                                    n_await   = 1'b1;
                                end
                                if (w_hb_due && w_tr_due) begin
                                    w_res0 = mk_msg(SEND_HB, 32'(r_send_seq), 16'd0, 1'b0,
                                                    32'd0, R_NONE);
                                    w_res1 = mk_msg(SEND_TR, 32'(w_send_p1), 16'd0, 1'b1,
                                                    r_pend_id + 32'd1, R_NONE);
                                    w_nres     = 2'd2;
                                    n_send_seq = w_send_p2;
                                end else if (w_hb_due) begin
                                    w_res0 = mk_msg(SEND_HB, 32'(r_send_seq), 16'd0, 1'b0,
                                                    32'd0, R_NONE);
                                    w_nres     = 2'd1;
                                    n_send_seq = w_send_p1;
                                end else if (w_tr_due) begin
                                    w_res0 = mk_msg(SEND_TR, 32'(r_send_seq), 16'd0, 1'b1,
                                                    r_pend_id + 32'd1, R_NONE);
                                    w_nres     = 2'd1;
                                    n_send_seq = w_send_p1;
                                end
                                if (w_hb_due || w_tr_due) n_idle_send = '0;
                            end
                        end
                    end
                end
                EV_LOGOUT: begin
                    if (r_run) begin
                        if (r_mode == MODE_LOGON) begin
                            w_res0 = mk_note(R_LOGOUT_IN_LOGON);
                            w_nres = 2'd1;
                            n_run  = 1'b0;
                            n_shut = 1'b1;
                            n_mode = MODE_DISC;
                        end else if (r_mode == MODE_EST) begin
                            w_res0      = mk_msg(SEND_LOGOFF, 32'(r_send_seq), 16'd0, 1'b0,
                                                 32'd0, R_NONE);
                            w_nres      = 2'd1;
                            n_send_seq  = w_send_p1;
                            n_idle_send = '0;
                            n_mode      = MODE_LOGOUT;
                            n_logout_s  = 8'd0;
                        end
                    end
                end
                default: ;
            endcase
            w_res0.last = (w_nres == 2'd1);
            w_res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISC;
            r_run       <= 1'b0;
            r_shut      <= 1'b0;
            r_recv_seq  <= SEQ_WIDTH'(1);
            r_send_seq  <= SEQ_WIDTH'(1);
            r_hb        <= RST_INIT_HB;
            r_idle_recv <= '0;
            r_idle_send <= '0;
            r_await     <= 1'b0;
            r_pend_id   <= 32'd0;
            r_logout_s  <= 8'd0;
            r_cnt       <= 2'd0;
        end else begin
            r_mode      <= n_mode;
            r_run       <= n_run;
            r_shut      <= n_shut;
            r_recv_seq  <= n_recv_seq;
            r_send_seq  <= n_send_seq;
            r_hb        <= n_hb;
            r_idle_recv <= n_idle_recv;
            r_idle_send <= n_idle_send;
            r_await     <= n_await;
            r_pend_id   <= n_pend_id;
            r_logout_s  <= n_logout_s;
            if (w_pop)       r_cnt <= w_nres;
            else if (w_take) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_res0 <= w_res0;
            r_res1 <= w_res1;
        end else if (w_take) begin
            r_res0 <= r_res1;
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.out_kind      = r_res0.kind;
    assign o_out.out_type      = r_res0.typ;
    assign o_out.out_seq       = r_res0.seq;
    assign o_out.out_heartbeat = r_res0.hb;
    assign o_out.out_has_id    = r_res0.has_id;
    assign o_out.out_id        = r_res0.id;
    assign o_out.out_reason    = r_res0.reason;
    assign o_out.out_last      = r_res0.last;

endmodule

// ===== rtl/core/fix_session_layer_fsm_top.sv =====
// top level of the fix session layer: config registers, front, queue, back
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          func, msg_kind, msg_seq, msg_heartbeat, msg_has_id, msg_id
//  o_out     out  valid/ready          out_kind .. out_last, one result per transfer
//  apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// an event is classified on transfer and waits in a two-entry queue; the back end
// takes one event per cycle when its two-result buffer is empty or drains in that cycle
// events with no result or one result go at one per cycle while the output takes results;
// a two-result event holds off the next until the single output port drains the buffer
// synchronous active-low reset restores the session state and register defaults
// a stalled output fills the buffer, then the queue, then drops input ready
`timescale 1ns / 1ps
module fix_session_layer_fsm_top #(
    parameter int SEQ_WIDTH   = fsl_pkg::SEQ_WIDTH_DEF,
    parameter int TIMER_WIDTH = fsl_pkg::TIMER_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fsl_in_if.sink                      i_in,
    fsl_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fsl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fsl_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic     w_push_valid, w_push_ready, w_evt_valid, w_evt_ready;
    t_evt     w_push_data, w_evt;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_server <= RST_IS_SERVER;
            r_cfg.init_hb   <= RST_INIT_HB;
            r_cfg.min_hb    <= RST_MIN_HB;
            r_cfg.max_hb    <= RST_MAX_HB;
            r_cfg.logout_to <= RST_LOGOUT_TO;
        end else if (w_wr) begin
            case (w_idx)
                REG_IS_SERVER: r_cfg.is_server <= pwdata[0];
                REG_INIT_HB:   r_cfg.init_hb   <= pwdata[15:0];
                REG_MIN_HB:    r_cfg.min_hb    <= pwdata[15:0];
                REG_MAX_HB:    r_cfg.max_hb    <= pwdata[15:0];
                REG_LOGOUT_TO: r_cfg.logout_to <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_IS_SERVER: prdata = {31'd0, r_cfg.is_server};
            REG_INIT_HB:   prdata = {16'd0, r_cfg.init_hb};
            REG_MIN_HB:    prdata = {16'd0, r_cfg.min_hb};
            REG_MAX_HB:    prdata = {16'd0, r_cfg.max_hb};
            REG_LOGOUT_TO: prdata = {24'd0, r_cfg.logout_to};
            default:       prdata = 32'd0;
        endcase
    end

    fsl_front u_front (
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    fsl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_evt_valid),
        .i_pop_ready  (w_evt_ready),
        .o_pop_data   (w_evt)
    );

    fsl_back #(
        .SEQ_WIDTH   (SEQ_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_evt_valid (w_evt_valid),
        .o_evt_ready (w_evt_ready),
        .i_evt       (w_evt),
        .o_out       (o_out)
    );

endmodule
